/* src/sha1s_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_pkg
// shared types and constants of the streaming sha-1 hasher
// ----------------------------------------------------------------------------
package sha1s_pkg;

    localparam int unsigned HashWords = 5;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds = 80;

    typedef logic [HashWords-1:0][31:0] hash_words_t;

    localparam hash_words_t HASH_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    // control from the sequencer to the compression unit
    typedef struct packed {
        logic start;
        logic restart;
    } sha1s_ctrl_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_FINAL
    } core_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DATA,
        S_PAD,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_COMP,
        S_EMIT
    } seq_state_t;

endpackage

/* src/sha1s_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_core
// sha-1 compression unit: one round per cycle over a rolling 16-word schedule,
// then a final step that folds the working variables into the chaining hash
// ----------------------------------------------------------------------------
module sha1s_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha1s_pkg::sha1s_ctrl_t    ctrl,
    output logic [3:0]                rd_addr,
    input  logic [31:0]               rd_data,
    output logic                      done,
    output sha1s_pkg::hash_words_t    hash
);
    import sha1s_pkg::*;

    core_state_t            state_reg, state_next;
    logic [6:0]             round_reg, round_next;
    logic [6:0]             round_inc;
    hash_words_t            h_reg;
    logic [31:0]            a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [15:0][31:0]      win_reg;
    logic [31:0]            w_cur;
    logic [31:0]            w_mix;
    logic [31:0]            f_val;
    logic [31:0]            k_val;
    logic [31:0]            t_val;

    assign round_inc = round_reg + 7'd1;
    assign hash = h_reg;

    // schedule: win_reg[0] is w[i-16], win_reg[15] is w[i-1]
    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur = (round_reg < 7'd16) ? rd_data : {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_ROUND0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_ROUND2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        done = 1'b0;
        rd_addr = 4'd0;
        case (state_reg)
            C_IDLE:
            begin
                round_next = 7'd0;
                if (ctrl.start)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                // buffer read is registered, so fetch one word ahead
                rd_addr = round_inc[3:0];
                round_next = round_inc;
                if (round_reg == 7'(Rounds - 1))
                begin
                    state_next = C_FINAL;
                end
            end
            C_FINAL:
            begin
                done = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= HASH_INIT;
        end
        else if (ctrl.restart)
        begin
            h_reg <= HASH_INIT;
        end
        else if (state_reg == C_FINAL)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && ctrl.start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (state_reg == C_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            win_reg <= {w_cur, win_reg[15:1]};
        end
    end

endmodule

/* src/sha1_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// streaming sha-1 hasher: word buffer, padding sequencer and digest output
// ----------------------------------------------------------------------------
// A request that is not the last word of a message is taken without a stall,
// except every sixteenth word, which fills the block buffer and holds the
// input while the compression unit runs its 80 rounds (one per cycle) and
// folds the result into the chaining hash. The last word starts the padding
// sequencer, which writes the held data word (only if all four bytes are
// valid, else they go into the pad word), the pad word, the zero fill and
// the two length words one per cycle, pausing in S_ZERO before the length
// words and for a compression each time a block fills (one or two in all),
// then hands out the five digest words, one per cycle while the output is
// not stalled. The block accepts nothing until the fifth digest word sits in
// the output register; that word may still be waiting while the next message
// starts. On long messages the sustained rate is set by the single round unit.
module sha1_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    import sha1s_pkg::*;

    seq_state_t         state_reg, state_next;
    seq_state_t         ret_reg, ret_next;
    logic [3:0]         wib_reg, wib_next;
    logic [60:0]        bytes_reg, bytes_next;
    logic [31:0]        hold_data_reg, hold_data_next;
    logic [2:0]         hold_vb_reg, hold_vb_next;
    logic [2:0]         emit_idx_reg, emit_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        digest_word_reg;
    logic [2:0]         word_index_reg;
    logic               digest_last_reg;
    logic               out_load;

    logic [31:0]        buf_mem [BlockWords];
    logic [31:0]        rd_data_reg;
    logic [3:0]         rd_addr;

    logic               push_en;
    logic [31:0]        push_word;
    seq_state_t         push_after;
    logic               in_take;
    logic [2:0]         vb_sat;
    logic [31:0]        pad_word;
    logic [63:0]        bit_len;

    sha1s_ctrl_t        core_ctrl;
    logic               core_done;
    hash_words_t        hash;

    sha1s_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (core_ctrl),
        .rd_addr (rd_addr),
        .rd_data (rd_data_reg),
        .done    (core_done),
        .hash    (hash)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take = in_valid && !in_stall;
    assign vb_sat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    assign bit_len = {bytes_reg, 3'b000};

    // valid bytes kept, the 0x80 marker right after them
    always_comb
    begin
        case (hold_vb_reg)
            3'd1:    pad_word = {hold_data_reg[31:24], 24'h800000};
            3'd2:    pad_word = {hold_data_reg[31:16], 16'h8000};
            3'd3:    pad_word = {hold_data_reg[31:8], 8'h80};
            default: pad_word = PAD_WORD;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        wib_next = wib_reg;
        bytes_next = bytes_reg;
        hold_data_next = hold_data_reg;
        hold_vb_next = hold_vb_reg;
        emit_idx_next = emit_idx_reg;
        push_en = 1'b0;
        push_word = 32'd0;
        push_after = state_reg;
        out_load = 1'b0;
        core_ctrl.start = 1'b0;
        core_ctrl.restart = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (!last)
                    begin
                        push_en = 1'b1;
                        push_word = data_word;
                        push_after = S_IDLE;
                        bytes_next = bytes_reg + 61'd4;
                    end
                    else
                    begin
                        bytes_next = bytes_reg + 61'(vb_sat);
                        hold_data_next = data_word;
                        hold_vb_next = vb_sat;
                        state_next = (vb_sat == 3'd4) ? S_DATA : S_PAD;
                    end
                end
            end
            S_DATA:
            begin
                push_en = 1'b1;
                push_word = hold_data_reg;
                push_after = S_PAD;
            end
            S_PAD:
            begin
                push_en = 1'b1;
                push_word = pad_word;
                push_after = S_ZERO;
            end
            S_ZERO:
            begin
                // zero fill up to the two length words, wrapping a block if needed
                if (wib_reg == 4'd14)
                begin
                    state_next = S_LEN_HI;
                end
                else
                begin
                    push_en = 1'b1;
                    push_after = S_ZERO;
                end
            end
            S_LEN_HI:
            begin
                push_en = 1'b1;
                push_word = bit_len[63:32];
                push_after = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                push_en = 1'b1;
                push_word = bit_len[31:0];
                push_after = S_EMIT;
            end
            S_COMP:
            begin
                if (core_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    emit_idx_next = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == 3'(HashWords - 1))
                    begin
                        emit_idx_next = 3'd0;
                        core_ctrl.restart = 1'b1;
                        bytes_next = 61'd0;
                        wib_next = 4'd0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            wib_next = wib_reg + 4'd1;
            if (wib_reg == 4'(BlockWords - 1))
            begin
                core_ctrl.start = 1'b1;
                ret_next = push_after;
                state_next = S_COMP;
            end
            else
            begin
                state_next = push_after;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            wib_reg <= 4'd0;
            bytes_reg <= 61'd0;
            emit_idx_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            wib_reg <= wib_next;
            bytes_reg <= bytes_next;
            emit_idx_reg <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
        hold_vb_reg <= hold_vb_next;
        if (out_load)
        begin
            digest_word_reg <= hash[emit_idx_reg];
            word_index_reg <= emit_idx_reg;
            digest_last_reg <= (emit_idx_reg == 3'(HashWords - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            buf_mem[wib_reg] <= push_word;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign digest_word = digest_word_reg;
    assign word_index = word_index_reg;
    assign digest_last = digest_last_reg;

endmodule
